// ----- src/clr_pkg.sv -----
// shared types and constants for the clipped line rasterizer
`timescale 1ns / 1ps

package clr_pkg;

  // coordinate and register widths
  localparam int COORD_W = 6;
  localparam int REG_W   = 7;
  localparam int IDX_W   = 2;

  // largest effective screen size; register values above saturate here
  localparam int SCREEN_MAX = 64;
  localparam logic [REG_W-1:0] SCREEN_MAX_C = REG_W'(SCREEN_MAX);
  localparam logic [REG_W-1:0] REG_RESET    = 7'd64;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_HEIGHT = 2'd1;

  // restoring divider: one quotient bit per cycle
  localparam int DIV_STEPS = COORD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // starting point and run end of one segment
  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] stop;
    logic               vert;
  } clr_geo_t;

  // per-column y step: whole part and fractional numerator over dx
  typedef struct packed {
    logic signed [COORD_W:0] qd;
    logic [COORD_W-1:0]      rinc;
  } clr_slope_t;

endpackage

// ----- src/clipped_line_rasterizer.sv -----
// top level of the clipped line rasterizer: sequencer, config and clip
`timescale 1ns / 1ps
//
// Takes one line segment request (start_x, start_y, end_x, end_y) on the in_
// channel and emits one point request per stepped column on the out_ channel,
// left to right, with out_last on the final point. A vertical segment steps
// y upward instead. Each point carries its column, its framebuffer row
// (screen_height - y) and a visible flag for the window x < width,
// 1 <= y < height; invisible points report row 0.
// Sequence: a non-vertical segment is accepted, passes through the restoring
// slope divider (one quotient bit per cycle), loads the slope and then emits
// one point per cycle while out_ does not stall; a vertical segment skips the
// divider and the slope load. in_stall stays high from accept until the last
// point has been loaded into the output register, so one segment is worked
// on at a time. A stall on out_ holds the output register and freezes the
// walker. The cfg_ port writes screen_width (index 0) and screen_height
// (index 1), saturated to 64 on use; write only while idle. Reset sets both
// to 64 and empties the output register.
//
module clipped_line_rasterizer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [clr_pkg::COORD_W-1:0] in_start_x,
  input  logic [clr_pkg::COORD_W-1:0] in_start_y,
  input  logic [clr_pkg::COORD_W-1:0] in_end_x,
  input  logic [clr_pkg::COORD_W-1:0] in_end_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [clr_pkg::COORD_W-1:0] out_column,
  output logic [clr_pkg::COORD_W-1:0] out_row,
  output logic                        out_visible,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic [clr_pkg::IDX_W-1:0]   cfg_index,
  input  logic [clr_pkg::REG_W-1:0]   cfg_wdata
);
  import clr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_RUN  = 3'b100
  } clr_state_t;

  clr_state_t         state_r, state_nxt;
  logic [REG_W-1:0]   width_r, width_nxt;
  logic [REG_W-1:0]   height_r, height_nxt;
  logic [COORD_W-1:0] dx_r, dx_nxt;
  logic               neg_r, neg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic               vis_r, vis_nxt;
  logic               last_r, last_nxt;

  logic               accept;
  logic               vert;
  logic               ltr;
  logic [COORD_W-1:0] dx_in;
  logic [COORD_W-1:0] dymag_in;
  logic               neg_in;
  logic [COORD_W-1:0] ymin;
  logic [COORD_W-1:0] ymax;
  clr_geo_t           geo;
  clr_slope_t         slope;
  logic               div_start;
  logic               div_done;
  logic [COORD_W-1:0] quot;
  logic [COORD_W-1:0] rem;
  logic               slope_ld;
  logic               out_free;
  logic               emit;
  logic               adv;
  logic [COORD_W-1:0] pt_x;
  logic [COORD_W-1:0] pt_y;
  logic               pt_last;
  logic [REG_W-1:0]   w_eff;
  logic [REG_W-1:0]   h_eff;
  logic               pt_vis;
  logic [REG_W-1:0]   pt_row;

  assign accept = in_valid && !in_stall;

  // segment setup: orient left to right, take slope sign and magnitude
  assign vert  = in_start_x == in_end_x;
  assign ltr   = in_start_x < in_end_x;
  assign dx_in = ltr ? (in_end_x - in_start_x) : (in_start_x - in_end_x);
  assign ymin  = (in_start_y < in_end_y) ? in_start_y : in_end_y;
  assign ymax  = (in_start_y < in_end_y) ? in_end_y : in_start_y;
  // normalized dy is negative when the right end is lower
  assign neg_in   = ltr ? (in_end_y < in_start_y) : (in_start_y < in_end_y);
  assign dymag_in = ymax - ymin;

  always_comb begin
    if (vert) begin
      geo.x0   = in_start_x;
      geo.y0   = ymin;
      geo.stop = ymax;
      geo.vert = 1'b1;
    end else begin
      geo.x0   = ltr ? in_start_x : in_end_x;
      geo.y0   = ltr ? in_start_y : in_end_y;
      geo.stop = ltr ? in_end_x : in_start_x;
      geo.vert = 1'b0;
    end
  end

  assign div_start = accept && !vert;

  clr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (dymag_in),
    .den   (dx_in),
    .done  (div_done),
    .quot  (quot),
    .rem   (rem)
  );

  // floor division of the signed slope from the magnitude result
  always_comb begin
    if (!neg_r) begin
      slope.qd   = $signed({1'b0, quot});
      slope.rinc = rem;
    end else if (rem == '0) begin
      slope.qd   = -$signed({1'b0, quot});
      slope.rinc = '0;
    end else begin
      slope.qd   = -$signed({1'b0, quot}) - 7'sd1;
      slope.rinc = dx_r - rem;
    end
  end

  assign slope_ld = (state_r == ST_DIV) && div_done;

  // output register takes a point when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (state_r == ST_RUN) && out_free;
  assign adv      = emit && !pt_last;

  clr_walk u_walk (
    .clk      (clk),
    .load     (accept),
    .geo      (geo),
    .slope_ld (slope_ld),
    .slope    (slope),
    .adv      (adv),
    .dx       (dx_r),
    .pt_x     (pt_x),
    .pt_y     (pt_y),
    .pt_last  (pt_last)
  );

  // clip window with saturated screen size
  assign w_eff  = (width_r > SCREEN_MAX_C) ? SCREEN_MAX_C : width_r;
  assign h_eff  = (height_r > SCREEN_MAX_C) ? SCREEN_MAX_C : height_r;
  assign pt_vis = ({1'b0, pt_x} < w_eff) && (pt_y != '0) && ({1'b0, pt_y} < h_eff);
  assign pt_row = h_eff - {1'b0, pt_y};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = vert ? ST_RUN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (emit && pt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // segment registers kept for the slope fixup
  always_comb begin
    dx_nxt  = dx_r;
    neg_nxt = neg_r;
    if (accept) begin
      dx_nxt  = dx_in;
      neg_nxt = neg_in;
    end
  end

  // configuration writes
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_nxt  = cfg_wdata;
        CFG_HEIGHT: height_nxt = cfg_wdata;
        default:    ;
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    vis_nxt       = vis_r;
    last_nxt      = last_r;
    if (out_free) begin
      out_valid_nxt = emit;
    end
    if (emit) begin
      col_nxt  = pt_x;
      row_nxt  = pt_vis ? pt_row[COORD_W-1:0] : '0;
      vis_nxt  = pt_vis;
      last_nxt = pt_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= REG_RESET;
      height_r    <= REG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r   <= dx_nxt;
    neg_r  <= neg_nxt;
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    vis_r  <= vis_nxt;
    last_r <= last_nxt;
  end

  assign in_stall    = state_r != ST_IDLE;
  assign out_valid   = out_valid_r;
  assign out_column  = col_r;
  assign out_row     = row_r;
  assign out_visible = vis_r;
  assign out_last    = last_r;

endmodule

// ----- src/clr_div.sv -----
// iterative restoring divider for the slope magnitude
`timescale 1ns / 1ps

module clr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [clr_pkg::COORD_W-1:0] num,
  input  logic [clr_pkg::COORD_W-1:0] den,
  output logic                        done,
  output logic [clr_pkg::COORD_W-1:0] quot,
  output logic [clr_pkg::COORD_W-1:0] rem
);
  import clr_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [COORD_W-1:0] q_r, q_nxt;
  logic [COORD_W-1:0] rem_r, rem_nxt;
  logic [COORD_W-1:0] den_r, den_nxt;
  logic [COORD_W:0]   shifted;
  logic [COORD_W:0]   diff;
  logic               ge;

  // one shift and trial subtract per cycle
  assign shifted = {rem_r, q_r[COORD_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      q_nxt   = {q_r[COORD_W-2:0], ge};
      rem_nxt = ge ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

// ----- src/clr_walk.sv -----
// point walker: steps x (or y for vertical runs) with an exact remainder
`timescale 1ns / 1ps

module clr_walk (
  input  logic                        clk,
  input  logic                        load,
  input  clr_pkg::clr_geo_t           geo,
  input  logic                        slope_ld,
  input  clr_pkg::clr_slope_t         slope,
  input  logic                        adv,
  input  logic [clr_pkg::COORD_W-1:0] dx,
  output logic [clr_pkg::COORD_W-1:0] pt_x,
  output logic [clr_pkg::COORD_W-1:0] pt_y,
  output logic                        pt_last
);
  import clr_pkg::*;

  logic [COORD_W-1:0]   x_r, x_nxt;
  logic [COORD_W-1:0]   y_r, y_nxt;
  logic [COORD_W-1:0]   err_r, err_nxt;
  logic [COORD_W-1:0]   stop_r, stop_nxt;
  logic                 vert_r, vert_nxt;
  clr_slope_t           slope_r, slope_nxt;
  logic [COORD_W:0]     e_sum;
  logic                 carry;
  logic [COORD_W:0]     e_red;
  logic signed [COORD_W+1:0] y_step;

  // remainder accumulate and carry into y
  assign e_sum  = {1'b0, err_r} + {1'b0, slope_r.rinc};
  assign carry  = e_sum >= {1'b0, dx};
  assign e_red  = e_sum - {1'b0, dx};
  assign y_step = $signed({2'b00, y_r}) + (COORD_W+2)'(slope_r.qd)
                  + $signed({{(COORD_W+1){1'b0}}, carry});

  always_comb begin
    x_nxt     = x_r;
    y_nxt     = y_r;
    err_nxt   = err_r;
    stop_nxt  = stop_r;
    vert_nxt  = vert_r;
    slope_nxt = slope_r;
    if (load) begin
      x_nxt    = geo.x0;
      y_nxt    = geo.y0;
      err_nxt  = '0;
      stop_nxt = geo.stop;
      vert_nxt = geo.vert;
    end else if (adv) begin
      if (vert_r) begin
        y_nxt = y_r + 1'b1;
      end else begin
        x_nxt   = x_r + 1'b1;
        y_nxt   = y_step[COORD_W-1:0];
        err_nxt = carry ? e_red[COORD_W-1:0] : e_sum[COORD_W-1:0];
      end
    end
    if (slope_ld) begin
      slope_nxt = slope;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    err_r   <= err_nxt;
    stop_r  <= stop_nxt;
    vert_r  <= vert_nxt;
    slope_r <= slope_nxt;
  end

  assign pt_x    = x_r;
  assign pt_y    = y_r;
  assign pt_last = vert_r ? (y_r == stop_r) : (x_r == stop_r);

endmodule
